// ===== src/timer_with_pre_and_postscaler_unit_macros.svh =====
// assertion macros used by the timer core rtl
`ifndef TIMER_WITH_PRE_AND_POSTSCALER_UNIT_MACROS_SVH
`define TIMER_WITH_PRE_AND_POSTSCALER_UNIT_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define TMR_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("timer assertion failed");
// next-cycle implication
`define TMR_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("timer assertion failed");
`else
`define TMR_ASSERT_IMP(label, clk, rst, ante, cons)
`define TMR_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== src/tmr_pkg.sv =====
// types, codes and helpers for the period timer
package tmr_pkg;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ADDR_COUNT   = 2'd0,
    ADDR_PERIOD  = 2'd1,
    ADDR_CONTROL = 2'd2,
    ADDR_FLAGS   = 2'd3
  } addr_t;

  localparam logic [7:0] PERIOD_RESET = 8'd255;

  typedef struct packed {
    logic [1:0] op;
    logic [1:0] reg_addr;
    logic [7:0] wdata;
  } item_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic       period_match;
    logic       flag_set;
    logic       irq;
  } result_t;

  // last prescaler count before rollover: 1:1, 1:4, 1:16
  function automatic logic [3:0] prescale_last(input logic [1:0] sel);
    logic [3:0] last;
    case (sel)
      2'd0:    last = 4'd0;
      2'd1:    last = 4'd3;
      default: last = 4'd15;
    endcase
    return last;
  endfunction

endpackage

// ===== src/tmr_in_if.sv =====
// command channel: tick, read or write
interface tmr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [1:0] reg_addr;
  logic [7:0] wdata;

  modport source (output valid, op, reg_addr, wdata, input ready);
  modport sink (input valid, op, reg_addr, wdata, output ready);
endinterface

// response channel: one result per command
interface tmr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] rdata;
  logic       period_match;
  logic       flag_set;
  logic       irq;

  modport source (output valid, rdata, period_match, flag_set, irq, input ready);
  modport sink (input valid, rdata, period_match, flag_set, irq, output ready);
endinterface

// ===== src/tmr_in_stage.sv =====
// input register for the command channel
module tmr_in_stage
  import tmr_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  tmr_in_if.sink  cmd,
  input  logic    advance,
  output logic    item_valid,
  output item_t   item
);

  assign cmd.ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (cmd.ready) begin
      item_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ready && cmd.valid) begin
      item <= '{op: cmd.op, reg_addr: cmd.reg_addr, wdata: cmd.wdata};
    end
  end

endmodule

// ===== src/tmr_core.sv =====
// timer registers, scalers and per-item update
module tmr_core
  import tmr_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    fire,
  input  item_t   item,
  output result_t result
);

  `include "timer_with_pre_and_postscaler_unit_macros.svh"

  logic [7:0] count_value, count_value_next;
  logic [7:0] period_value, period_value_next;
  logic [6:0] control_value, control_value_next;
  logic [3:0] prescale_count, prescale_count_next;
  logic [3:0] postscale_count, postscale_count_next;
  logic       int_flag, int_flag_next;
  logic       int_enable, int_enable_next;

  logic       tick, read, write;
  logic       rollover;
  logic       match;
  logic       post_done;
  logic [7:0] rdata;

  assign tick  = (item.op == OP_TICK);
  assign read  = (item.op == OP_READ);
  assign write = (item.op == OP_WRITE);

  assign rollover  = control_value[2] && (prescale_count >= prescale_last(control_value[1:0]));
  assign match     = rollover && (count_value == period_value);
  assign post_done = postscale_count >= control_value[6:3];

  always_comb begin
    rdata = 8'd0;
    if (read) begin
      case (item.reg_addr)
        ADDR_COUNT:   rdata = count_value;
        ADDR_PERIOD:  rdata = period_value;
        ADDR_CONTROL: rdata = {1'b0, control_value};
        ADDR_FLAGS:   rdata = {6'd0, int_enable, int_flag};
        default:      rdata = 8'd0;
      endcase
    end
  end

  always_comb begin
    count_value_next     = count_value;
    period_value_next    = period_value;
    control_value_next   = control_value;
    prescale_count_next  = prescale_count;
    postscale_count_next = postscale_count;
    int_flag_next        = int_flag;
    int_enable_next      = int_enable;
    if (tick && control_value[2]) begin
      if (!rollover) begin
        prescale_count_next = prescale_count + 4'd1;
      end else begin
        prescale_count_next = 4'd0;
        if (match) begin
          count_value_next = 8'd0;
          if (post_done) begin
            postscale_count_next = 4'd0;
            int_flag_next        = 1'b1;
          end else begin
            postscale_count_next = postscale_count + 4'd1;
          end
        end else begin
          count_value_next = count_value + 8'd1;
        end
      end
    end else if (write) begin
      case (item.reg_addr)
        ADDR_COUNT: begin
          count_value_next     = item.wdata;
          prescale_count_next  = 4'd0;
          postscale_count_next = 4'd0;
        end
        ADDR_PERIOD: begin
          period_value_next = item.wdata;
        end
        ADDR_CONTROL: begin
          control_value_next   = item.wdata[6:0];
          prescale_count_next  = 4'd0;
          postscale_count_next = 4'd0;
        end
        default: begin
          int_flag_next   = item.wdata[0];
          int_enable_next = item.wdata[1];
        end
      endcase
    end
  end

  always_comb begin
    result.rdata        = rdata;
    result.period_match = tick && match;
    result.flag_set     = tick && match && post_done;
    result.irq          = int_flag_next && int_enable_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_value     <= 8'd0;
      period_value    <= PERIOD_RESET;
      control_value   <= 7'd0;
      prescale_count  <= 4'd0;
      postscale_count <= 4'd0;
      int_flag        <= 1'b0;
      int_enable      <= 1'b0;
    end else if (fire) begin
      count_value     <= count_value_next;
      period_value    <= period_value_next;
      control_value   <= control_value_next;
      prescale_count  <= prescale_count_next;
      postscale_count <= postscale_count_next;
      int_flag        <= int_flag_next;
      int_enable      <= int_enable_next;
    end
  end

  `TMR_ASSERT_IMP(a_flag_needs_match, clk, rst, fire && result.flag_set, result.period_match)
  `TMR_ASSERT_NXT(a_flag_after_set, clk, rst, fire && result.flag_set, int_flag)
  `TMR_ASSERT_NXT(a_count_wr_clears, clk, rst,
    fire && write && (item.reg_addr == ADDR_COUNT),
    prescale_count == 4'd0 && postscale_count == 4'd0)
  `TMR_ASSERT_NXT(a_off_holds_count, clk, rst,
    fire && tick && !control_value[2], $stable(count_value))

endmodule

// ===== src/timer_with_pre_and_postscaler_unit.sv =====
// period timer top level: input register, timer core, result register
//
// Each command (tick, register read or register write) is evaluated
// combinationally in the core; a new command is accepted every cycle as
// long as the result register is free or being drained in the same cycle.
// A command goes from transfer into the input register, then into the
// result register, where the timer state is updated as the result is
// loaded. A stalled response channel stalls the input after two items.
module timer_with_pre_and_postscaler_unit
  import tmr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  tmr_in_if.sink    cmd,
  tmr_out_if.source rsp
);

  logic    item_valid;
  item_t   item;
  logic    advance;
  logic    fire;
  result_t result;
  result_t result_q;
  logic    result_valid;

  assign advance = !result_valid || rsp.ready;
  assign fire    = item_valid && advance;

  tmr_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  tmr_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (item),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result_q <= result;
    end
  end

  assign rsp.valid        = result_valid;
  assign rsp.rdata        = result_q.rdata;
  assign rsp.period_match = result_q.period_match;
  assign rsp.flag_set     = result_q.flag_set;
  assign rsp.irq          = result_q.irq;

endmodule

// ===== tb/sv/timer_with_pre_and_postscaler_unit_tb.sv =====
// self-checking testbench for the period timer with prescaler and postscaler
module timer_with_pre_and_postscaler_unit_tb;
  import tmr_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [1:0] PRE_DIV1 = 2'd0;
  localparam logic [1:0] PRE_DIV4 = 2'd1;
  localparam int CTL_EN_BIT = 2;
  localparam logic [7:0] CTL_ENABLE = 8'h04;
  localparam int STALL_LIMIT = 3000;
  localparam int TAIL_CYCLES = 8;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #6 clk = ~clk;

  tmr_in_if cmd ();
  tmr_out_if rsp ();

  timer_with_pre_and_postscaler_unit dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .rsp(rsp)
  );

  // shadow copy of the timer registers
  logic [7:0] m_count = '0;
  logic [7:0] m_period = PERIOD_RESET;
  logic [6:0] m_control = '0;
  logic [3:0] m_pre = '0;
  logic [3:0] m_post = '0;
  logic m_flag = 1'b0;
  logic m_ien = 1'b0;

  result_t pending_results[$];
  int errors = 0;
  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  int hold_request = 0;
  bit hold_taken = 1'b0;
  int hold_left = 0;
  int stall_cycles = 0;

  // advances the shadow timer by one command and returns the result it gives
  function automatic result_t timer_step(input item_t it);
    result_t r;
    int ratio;
    r = '0;
    case (it.op)
      OP_TICK: begin
        if (m_control[CTL_EN_BIT]) begin
          ratio = (m_control[1:0] == PRE_DIV1) ? 1 : (m_control[1:0] == PRE_DIV4) ? 4 : 16;
          if (int'(m_pre) + 1 >= ratio) begin
            m_pre = '0;
            if (m_count == m_period) begin
              m_count = '0;
              r.period_match = 1'b1;
              if (m_post >= m_control[6:3]) begin
                m_post = '0;
                m_flag = 1'b1;
                r.flag_set = 1'b1;
              end else begin
                m_post = m_post + 4'd1;
              end
            end else begin
              m_count = m_count + 8'd1;
            end
          end else begin
            m_pre = m_pre + 4'd1;
          end
        end
      end
      OP_READ: begin
        case (it.reg_addr)
          ADDR_COUNT:   r.rdata = m_count;
          ADDR_PERIOD:  r.rdata = m_period;
          ADDR_CONTROL: r.rdata = {1'b0, m_control};
          default:      r.rdata = {6'd0, m_ien, m_flag};
        endcase
      end
      OP_WRITE: begin
        case (it.reg_addr)
          ADDR_COUNT: begin
            m_count = it.wdata;
            m_pre = '0;
            m_post = '0;
          end
          ADDR_PERIOD: m_period = it.wdata;
          ADDR_CONTROL: begin
            m_control = it.wdata[6:0];
            m_pre = '0;
            m_post = '0;
          end
          default: begin
            m_flag = it.wdata[0];
            m_ien = it.wdata[1];
          end
        endcase
      end
      default: ;
    endcase
    r.irq = m_flag & m_ien;
    return r;
  endfunction

  // leaves valid high on return; the caller lowers it when the stream pauses
  task automatic send_item(input logic [1:0] op, input logic [1:0] addr,
                           input logic [7:0] wdata);
    item_t it;
    it = '{op: op, reg_addr: addr, wdata: wdata};
    while ($urandom_range(99) < src_idle_pct) begin
      cmd.valid <= 1'b0;
      @(posedge clk);
    end
    cmd.valid <= 1'b1;
    cmd.op <= op;
    cmd.reg_addr <= addr;
    cmd.wdata <= wdata;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
    pending_results.push_back(timer_step(it));
  endtask

  // response side: check each transfer, then pick ready for the next cycle
  always @(posedge clk) begin
    result_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: rdata %0h match %0b flag_set %0b irq %0b",
               rsp.rdata, rsp.period_match, rsp.flag_set, rsp.irq);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (rsp.rdata !== want.rdata) begin
          $error("rdata: expected %0h, got %0h", want.rdata, rsp.rdata);
          errors++;
        end
        if (rsp.period_match !== want.period_match) begin
          $error("period_match: expected %0b, got %0b", want.period_match, rsp.period_match);
          errors++;
        end
        if (rsp.flag_set !== want.flag_set) begin
          $error("flag_set: expected %0b, got %0b", want.flag_set, rsp.flag_set);
          errors++;
        end
        if (rsp.irq !== want.irq) begin
          $error("irq: expected %0b, got %0b", want.irq, rsp.irq);
          errors++;
        end
      end
    end
    if (hold_request > 0 && !hold_taken) begin
      hold_left = hold_request;
      hold_taken = 1'b1;
    end
    if (hold_left > 0) begin
      rsp.ready <= 1'b0;
      hold_left--;
    end else begin
      rsp.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (cmd.valid && cmd.ready) || (rsp.valid && rsp.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic test_reset_values();
    send_item(OP_READ, ADDR_COUNT, 8'h00);
    send_item(OP_READ, ADDR_PERIOD, 8'hFF);
    send_item(OP_READ, ADDR_CONTROL, 8'h00);
    send_item(OP_READ, ADDR_FLAGS, 8'hFF);
  endtask

  task automatic test_register_access();
    // bit 7 of control is dropped, timer stays off
    send_item(OP_WRITE, ADDR_CONTROL, 8'hFB);
    send_item(OP_READ, ADDR_CONTROL, 8'h00);
    send_item(OP_TICK, ADDR_COUNT, 8'hFF);
    send_item(OP_WRITE, ADDR_FLAGS, 8'hFF);
    send_item(OP_READ, ADDR_FLAGS, 8'h00);
    send_item(OP_UNUSED, ADDR_FLAGS, 8'hFF);
    send_item(OP_WRITE, ADDR_FLAGS, 8'hFC);
    send_item(OP_WRITE, ADDR_COUNT, 8'hFF);
    send_item(OP_READ, ADDR_COUNT, 8'h00);
  endtask

  task automatic test_match_and_postscale();
    send_item(OP_WRITE, ADDR_PERIOD, 8'h00);
    send_item(OP_WRITE, ADDR_FLAGS, 8'h02);
    // postscale 1:2, enabled, prescale 1:1
    send_item(OP_WRITE, ADDR_CONTROL, 8'h0C);
    // counter above period wraps through 255 first
    repeat (3) send_item(OP_TICK, ADDR_COUNT, 8'h00);
    send_item(OP_WRITE, ADDR_PERIOD, 8'h01);
    repeat (4) send_item(OP_TICK, ADDR_PERIOD, 8'h00);
    send_item(OP_WRITE, ADDR_FLAGS, 8'h02);
  endtask

  // mostly ticks on a running timer with short periods, so matches and
  // flags come often; the rest are register accesses and unused commands
  task automatic test_random(input int n);
    int pick;
    logic [7:0] w;
    send_item(OP_WRITE, ADDR_PERIOD, 8'($urandom_range(0, 6)));
    send_item(OP_WRITE, ADDR_CONTROL, 8'($urandom) | CTL_ENABLE);
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      w = 8'($urandom);
      if (pick < 70) begin
        send_item(OP_TICK, 2'($urandom_range(3)), w);
      end else if (pick < 78) begin
        send_item(OP_READ, 2'($urandom_range(3)), w);
      end else if (pick < 80) begin
        send_item(OP_UNUSED, 2'($urandom_range(3)), w);
      end else if (pick < 84) begin
        if ($urandom_range(3) != 0) w = 8'($urandom_range(0, 7));
        send_item(OP_WRITE, ADDR_PERIOD, w);
      end else if (pick < 88) begin
        if ($urandom_range(99) < 85) w = w | CTL_ENABLE;
        send_item(OP_WRITE, ADDR_CONTROL, w);
      end else if (pick < 92) begin
        if ($urandom_range(3) != 0) w = 8'($urandom_range(0, 7));
        send_item(OP_WRITE, ADDR_COUNT, w);
      end else begin
        send_item(OP_WRITE, ADDR_FLAGS, w);
      end
    end
  endtask

  // response side holds off while commands keep coming, so the input stalls
  task automatic test_backpressure();
    hold_request = 120;
    test_random(40);
  endtask

  initial begin
    cmd.valid <= 1'b0;
    cmd.op <= OP_TICK;
    cmd.reg_addr <= ADDR_COUNT;
    cmd.wdata <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_reset_values();
    test_register_access();
    test_match_and_postscale();

    src_idle_pct = 35;
    snk_idle_pct = 71;
    test_random(550);
    src_idle_pct = 71;
    snk_idle_pct = 35;
    test_random(550);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_backpressure();
    test_random(550);

    cmd.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
